// File: sv/hbh_pkg.sv
// hbh_pkg: shared constants for the hexagonal bin histogram.
// Used by hexagonal_bin_histogram, hbh_checker and the bench; no dependencies.
package hbh_pkg;

  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_COUNT_WIDTH = 24;

  localparam int COORD_W = 32;
  localparam int INV_W   = 32;
  localparam int GCOL_W  = 8;
  localparam int GROW_W  = 7;
  localparam int MINC_W  = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_INV     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_INV     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT = 3'd6;

  localparam logic [INV_W-1:0]  RST_INV       = 32'd65536;
  localparam logic [GCOL_W-1:0] RST_GRID_COLS = 8'd100;
  localparam logic [GROW_W-1:0] RST_GRID_ROWS = 7'd57;
  localparam logic [MINC_W-1:0] RST_MIN_COUNT = 24'd1;

  localparam logic MODE_BIN  = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic LAT_MAIN  = 1'b0;
  localparam logic LAT_OFFS  = 1'b1;

endpackage

// File: sv/hbh_count_mem.sv
// hbh_count_mem: single-port-write, single-port-read count memory,
// read data registered. No dependencies.
module hbh_count_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/hexagonal_bin_histogram.sv
// hexagonal_bin_histogram: two-lattice hexagonal binning with counts kept
// in two count memories. Depends on hbh_pkg and hbh_count_mem.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | input     | in_valid / in_ready    | mode, x/y coord, cell select
//  out_    | output    | out_valid / out_ready  | binned, hit cell, count, meets
//  cfg_    | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A point steps through states MX0 to WRITE (one shared 17x32 multiplier
// does four partial products), a read through PICK and WRITE (memory read,
// then write-back). One item is in flight at a time; the read-modify-write
// of a cell finishes before the next item is taken, so no forwarding.
// After reset a clearing pass zeroes both memories over (MAX_COLUMNS+1) *
// (MAX_ROWS+1) addresses (8385 by default); in_ready stays low meanwhile.
// A result waiting on out_ready holds the write-back and the next transfer.
module hexagonal_bin_histogram #(
  parameter int MAX_COLUMNS = hbh_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = hbh_pkg::DEF_MAX_ROWS,
  parameter int COUNT_WIDTH = hbh_pkg::DEF_COUNT_WIDTH,
  localparam int COL_W = $clog2(MAX_COLUMNS + 1),
  localparam int ROW_W = $clog2(MAX_ROWS + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [hbh_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [hbh_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                                in_lattice_select,
  input  logic [COL_W-1:0]                    in_column_select,
  input  logic [ROW_W-1:0]                    in_row_select,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_binned,
  output logic                                out_hit_lattice,
  output logic [COL_W-1:0]                    out_hit_column,
  output logic [ROW_W-1:0]                    out_hit_row,
  output logic [COUNT_WIDTH-1:0]              out_cell_count,
  output logic                                out_meets_minimum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hbh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hbh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int MAIN_DEPTH = (MAX_COLUMNS + 1) * (MAX_ROWS + 1);
  localparam int OFFS_DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int MAIN_AW = $clog2(MAIN_DEPTH);
  localparam int OFFS_AW = (OFFS_DEPTH > 1) ? $clog2(OFFS_DEPTH) : 1;
  localparam int CW      = hbh_pkg::COORD_W;
  localparam int MAG_W   = CW + 1;
  localparam int HALF_W  = MAG_W / 2 + 1;
  localparam int PROD_W  = HALF_W + hbh_pkg::INV_W;
  localparam int P_W     = MAG_W + hbh_pkg::INV_W;
  localparam int S_W     = P_W - 16 + 1;
  localparam int B_W     = S_W - 16;
  localparam int A_W     = B_W + 1;
  localparam int SQ_W    = 32;
  localparam int D_W     = SQ_W + 2;
  localparam int CMP_W   = 32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MX0   = 10'b0000000100,
    S_MX1   = 10'b0000001000,
    S_MY0   = 10'b0000010000,
    S_MY1   = 10'b0000100000,
    S_TY    = 10'b0001000000,
    S_SQ    = 10'b0010000000,
    S_PICK  = 10'b0100000000,
    S_WRITE = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [CW-1:0]             x_org_r, y_org_r;
  logic [hbh_pkg::INV_W-1:0]        x_inv_r, y_inv_r;
  logic [hbh_pkg::GCOL_W-1:0]       gcols_r;
  logic [hbh_pkg::GROW_W-1:0]       grows_r;
  logic [hbh_pkg::MINC_W-1:0]       minc_r;

  // item
  logic                    mode_r, lsel_r;
  logic [COL_W-1:0]        csel_r;
  logic [ROW_W-1:0]        rsel_r;
  logic [MAG_W-1:0]        xmag_r, ymag_r;
  logic                    xneg_r, yneg_r;
  logic [P_W-1:0]          p_r;
  logic signed [S_W-1:0]   sx_r, sy_r;
  logic signed [A_W-1:0]   ax_r, ay_r;
  logic signed [B_W-1:0]   bx_r, by_r;
  logic [SQ_W-1:0]         sqax_r, sqay_r, sqbx_r, sqby_r;

  // pick results
  logic                    ok_r, lat_r;
  logic [COL_W-1:0]        col_r;
  logic [ROW_W-1:0]        row_r;
  logic [MAIN_AW-1:0]      maddr_r;
  logic [OFFS_AW-1:0]      oaddr_r;
  logic [MAIN_AW-1:0]      clr_r;

  logic                    out_free;
  logic                    acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_org_r <= '0;
      y_org_r <= '0;
      x_inv_r <= hbh_pkg::RST_INV;
      y_inv_r <= hbh_pkg::RST_INV;
      gcols_r <= hbh_pkg::RST_GRID_COLS;
      grows_r <= hbh_pkg::RST_GRID_ROWS;
      minc_r  <= hbh_pkg::RST_MIN_COUNT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hbh_pkg::REG_X_ORIGIN:  x_org_r <= $signed(cfg_data[CW-1:0]);
        hbh_pkg::REG_Y_ORIGIN:  y_org_r <= $signed(cfg_data[CW-1:0]);
        hbh_pkg::REG_X_INV:     x_inv_r <= cfg_data[hbh_pkg::INV_W-1:0];
        hbh_pkg::REG_Y_INV:     y_inv_r <= cfg_data[hbh_pkg::INV_W-1:0];
        hbh_pkg::REG_GRID_COLS: gcols_r <= cfg_data[hbh_pkg::GCOL_W-1:0];
        hbh_pkg::REG_GRID_ROWS: grows_r <= cfg_data[hbh_pkg::GROW_W-1:0];
        hbh_pkg::REG_MIN_COUNT: minc_r  <= cfg_data[hbh_pkg::MINC_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate offsets, magnitude and sign
  logic signed [MAG_W-1:0] dx, dy;
  assign dx = MAG_W'(in_x_coord) - MAG_W'(x_org_r);
  assign dy = MAG_W'(in_y_coord) - MAG_W'(y_org_r);

  // shared partial-product multiplier
  logic [HALF_W-1:0]          mul_a;
  logic [hbh_pkg::INV_W-1:0]  mul_b;
  logic [PROD_W-1:0]          prod;

  always_comb begin
    mul_a = '0;
    mul_b = x_inv_r;
    case (state_r)
      S_MX0: mul_a = HALF_W'(xmag_r[15:0]);
      S_MX1: mul_a = HALF_W'(xmag_r[MAG_W-1:16]);
      S_MY0: begin
        mul_a = HALF_W'(ymag_r[15:0]);
        mul_b = y_inv_r;
      end
      S_MY1: begin
        mul_a = HALF_W'(ymag_r[MAG_W-1:16]);
        mul_b = y_inv_r;
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // signed Q.16 index from the accumulated product (floor toward -inf is
  // folded in as +0xFFFF on the magnitude for negative offsets)
  function automatic logic signed [S_W-1:0] to_s(input logic [P_W-1:0] p,
                                                 input logic neg);
    logic [S_W-1:0] m;
    m = S_W'(p[P_W-1:16]);
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // round half away from zero, floor, and distances for both axes
  logic [15:0]           fx, fy;
  logic                  incx, incy;
  logic signed [B_W-1:0] bx, by;
  logic signed [17:0]    dax, day, dbx, dby;
  logic [35:0]           sax, say, sbx, sby;

  always_comb begin
    fx   = sx_r[15:0];
    fy   = sy_r[15:0];
    bx   = sx_r[S_W-1:16];
    by   = sy_r[S_W-1:16];
    incx = sx_r[S_W-1] ? (fx > 16'h8000) : fx[15];
    incy = sy_r[S_W-1] ? (fy > 16'h8000) : fy[15];
    dax  = $signed({2'b00, fx}) - (incx ? 18'sh10000 : 18'sh0);
    day  = $signed({2'b00, fy}) - (incy ? 18'sh10000 : 18'sh0);
    dbx  = $signed({2'b00, fx}) - 18'sh08000;
    dby  = $signed({2'b00, fy}) - 18'sh08000;
    sax  = 36'($signed(36'(dax)) * $signed(36'(dax)));
    say  = 36'($signed(36'(day)) * $signed(36'(day)));
    sbx  = 36'($signed(36'(dbx)) * $signed(36'(dbx)));
    sby  = 36'($signed(36'(dby)) * $signed(36'(dby)));
  end

  // cell choice
  logic [COL_W-1:0]   nx;
  logic [ROW_W-1:0]   ny;
  logic [D_W-1:0]     d1, d2;
  logic               pick_main, ok_main, ok_offs;
  logic               ok_sel, lat_sel;
  logic [COL_W-1:0]   col_sel;
  logic [ROW_W-1:0]   row_sel;
  logic [COL_W-1:0]   c_use;
  logic [ROW_W-1:0]   r_use;

  always_comb begin
    if (gcols_r == '0)                    nx = COL_W'(1);
    else if (32'(gcols_r) > MAX_COLUMNS)  nx = COL_W'(MAX_COLUMNS);
    else                                  nx = COL_W'(gcols_r);
    if (grows_r == '0)                    ny = ROW_W'(1);
    else if (32'(grows_r) > MAX_ROWS)     ny = ROW_W'(MAX_ROWS);
    else                                  ny = ROW_W'(grows_r);

    d1 = D_W'(sqax_r) + D_W'(sqay_r) + (D_W'(sqay_r) << 1);
    d2 = D_W'(sqbx_r) + D_W'(sqby_r) + (D_W'(sqby_r) << 1);
    pick_main = d1 < d2;
    ok_main = !ax_r[A_W-1] && !ay_r[A_W-1]
           && ($signed(ax_r) <= $signed(A_W'(nx)))
           && ($signed(ay_r) <= $signed(A_W'(ny)));
    ok_offs = !bx_r[B_W-1] && !by_r[B_W-1]
           && ($signed(bx_r) < $signed(B_W'(nx)))
           && ($signed(by_r) < $signed(B_W'(ny)));

    if (mode_r == hbh_pkg::MODE_READ) begin
      lat_sel = lsel_r;
      if (lsel_r == hbh_pkg::LAT_MAIN)
        ok_sel = (32'(csel_r) <= MAX_COLUMNS) && (32'(rsel_r) <= MAX_ROWS);
      else
        ok_sel = (32'(csel_r) < MAX_COLUMNS) && (32'(rsel_r) < MAX_ROWS);
      col_sel = '0;
      row_sel = '0;
      c_use   = csel_r;
      r_use   = rsel_r;
    end else begin
      lat_sel = pick_main ? hbh_pkg::LAT_MAIN : hbh_pkg::LAT_OFFS;
      ok_sel  = pick_main ? ok_main : ok_offs;
      c_use   = pick_main ? ax_r[COL_W-1:0] : bx_r[COL_W-1:0];
      r_use   = pick_main ? ay_r[ROW_W-1:0] : by_r[ROW_W-1:0];
      col_sel = ok_sel ? c_use : '0;
      row_sel = ok_sel ? r_use : '0;
    end
  end

  // the pick stage drives the read address directly; the same address is
  // registered into maddr_r/oaddr_r for the write-back
  logic [MAIN_AW-1:0] maddr_nxt;
  logic [OFFS_AW-1:0] oaddr_nxt;
  assign maddr_nxt = MAIN_AW'(c_use) * MAIN_AW'(MAX_ROWS + 1) + MAIN_AW'(r_use);
  assign oaddr_nxt = OFFS_AW'(c_use) * OFFS_AW'(MAX_ROWS) + OFFS_AW'(r_use);

  // count memories
  logic                   m_we, o_we, m_re, o_re;
  logic [MAIN_AW-1:0]     m_waddr;
  logic [OFFS_AW-1:0]     o_waddr;
  logic [COUNT_WIDTH-1:0] m_wdata, o_wdata, m_rdata, o_rdata;
  logic [COUNT_WIDTH-1:0] rd_cnt, new_cnt, res_cnt;
  logic                   finish;

  assign finish  = (state_r == S_WRITE) && out_free;
  assign rd_cnt  = (lat_r == hbh_pkg::LAT_MAIN) ? m_rdata : o_rdata;
  assign new_cnt = (mode_r == hbh_pkg::MODE_READ) ? '0 :
                   ((rd_cnt == COUNT_MAX) ? rd_cnt : rd_cnt + 1'b1);
  assign res_cnt = (mode_r == hbh_pkg::MODE_READ && ok_r) ? rd_cnt : '0;

  assign m_re = (state_r == S_PICK) && (lat_sel == hbh_pkg::LAT_MAIN) && ok_sel;
  assign o_re = (state_r == S_PICK) && (lat_sel == hbh_pkg::LAT_OFFS) && ok_sel;

  always_comb begin
    if (state_r == S_CLEAR) begin
      m_we    = 1'b1;
      o_we    = (32'(clr_r) < OFFS_DEPTH);
      m_waddr = clr_r;
      o_waddr = OFFS_AW'(clr_r);
      m_wdata = '0;
      o_wdata = '0;
    end else begin
      m_we    = finish && ok_r && (lat_r == hbh_pkg::LAT_MAIN);
      o_we    = finish && ok_r && (lat_r == hbh_pkg::LAT_OFFS);
      m_waddr = maddr_r;
      o_waddr = oaddr_r;
      m_wdata = new_cnt;
      o_wdata = new_cnt;
    end
  end

  hbh_count_mem #(.DEPTH(MAIN_DEPTH), .AW(MAIN_AW), .DW(COUNT_WIDTH)) u_main_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .re(m_re), .raddr(maddr_nxt), .rdata(m_rdata)
  );

  hbh_count_mem #(.DEPTH(OFFS_DEPTH), .AW(OFFS_AW), .DW(COUNT_WIDTH)) u_offs_mem (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .re(o_re), .raddr(oaddr_nxt), .rdata(o_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (32'(clr_r) == MAIN_DEPTH - 1) state_nxt = S_IDLE;
      S_IDLE:  if (acc) state_nxt = (in_mode == hbh_pkg::MODE_READ) ? S_PICK : S_MX0;
      S_MX0:   state_nxt = S_MX1;
      S_MX1:   state_nxt = S_MY0;
      S_MY0:   state_nxt = S_MY1;
      S_MY1:   state_nxt = S_TY;
      S_TY:    state_nxt = S_SQ;
      S_SQ:    state_nxt = S_PICK;
      S_PICK:  state_nxt = S_WRITE;
      S_WRITE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (finish)         out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc) begin
      mode_r <= in_mode;
      lsel_r <= in_lattice_select;
      csel_r <= in_column_select;
      rsel_r <= in_row_select;
      xneg_r <= dx[MAG_W-1];
      yneg_r <= dy[MAG_W-1];
      xmag_r <= dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      ymag_r <= dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    end
    case (state_r)
      S_MX0: p_r <= P_W'(prod) + (xneg_r ? P_W'(16'hFFFF) : '0);
      S_MX1: p_r <= p_r + P_W'({prod, 16'h0000});
      S_MY0: begin
        sx_r <= to_s(p_r, xneg_r);
        p_r  <= P_W'(prod) + (yneg_r ? P_W'(16'hFFFF) : '0);
      end
      S_MY1: p_r <= p_r + P_W'({prod, 16'h0000});
      S_TY:  sy_r <= to_s(p_r, yneg_r);
      S_SQ: begin
        bx_r   <= bx;
        by_r   <= by;
        ax_r   <= A_W'(bx) + A_W'(incx);
        ay_r   <= A_W'(by) + A_W'(incy);
        sqax_r <= sax[SQ_W-1:0];
        sqay_r <= say[SQ_W-1:0];
        sqbx_r <= sbx[SQ_W-1:0];
        sqby_r <= sby[SQ_W-1:0];
      end
      S_PICK: begin
        ok_r    <= ok_sel;
        lat_r   <= lat_sel;
        col_r   <= col_sel;
        row_r   <= row_sel;
        maddr_r <= maddr_nxt;
        oaddr_r <= oaddr_nxt;
      end
      default: ;
    endcase
    if (finish) begin
      out_binned        <= (mode_r == hbh_pkg::MODE_BIN) && ok_r;
      out_hit_lattice   <= (mode_r == hbh_pkg::MODE_BIN) ? lat_r : 1'b0;
      out_hit_column    <= col_r;
      out_hit_row       <= row_r;
      out_cell_count    <= res_cnt;
      out_meets_minimum <= (mode_r == hbh_pkg::MODE_READ)
                        && (CMP_W'(res_cnt) >= CMP_W'(minc_r));
    end
  end

endmodule

// File: sv/hbh_checker.sv
// hbh_checker: port-level assertions for hexagonal_bin_histogram, bound
// to the top level below. Depends on hbh_pkg.
module hbh_checker #(
  parameter int MAX_COLUMNS = hbh_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = hbh_pkg::DEF_MAX_ROWS,
  parameter int COUNT_WIDTH = hbh_pkg::DEF_COUNT_WIDTH,
  localparam int COL_W = $clog2(MAX_COLUMNS + 1),
  localparam int ROW_W = $clog2(MAX_ROWS + 1)
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     out_binned,
  input logic                     out_hit_lattice,
  input logic [COL_W-1:0]         out_hit_column,
  input logic [ROW_W-1:0]         out_hit_row,
  input logic [COUNT_WIDTH-1:0]   out_cell_count,
  input logic                     out_meets_minimum
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("output valid or input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_count)
      && $stable(out_hit_column) && $stable(out_hit_row) && $stable(out_binned)
      && $stable(out_hit_lattice) && $stable(out_meets_minimum))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while an item is in flight");

  a_bin_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_binned |-> out_cell_count == '0 && !out_meets_minimum)
    else $error("binned point reports a count");

  a_drop_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_binned |-> out_hit_column == '0 && out_hit_row == '0)
    else $error("dropped item reports a cell");

endmodule

bind hexagonal_bin_histogram hbh_checker #(
  .MAX_COLUMNS(MAX_COLUMNS),
  .MAX_ROWS(MAX_ROWS),
  .COUNT_WIDTH(COUNT_WIDTH)
) u_hbh_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_valid),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_binned(out_binned),
  .out_hit_lattice(out_hit_lattice),
  .out_hit_column(out_hit_column),
  .out_hit_row(out_hit_row),
  .out_cell_count(out_cell_count),
  .out_meets_minimum(out_meets_minimum)
);

// File: test/hexagonal_bin_histogram_test.sv
// hexagonal_bin_histogram_test: self-checking bench for the hexagonal bin histogram.
// Needs hbh_pkg and the hexagonal_bin_histogram RTL; it predicts every result
// with its own copy of both count stores and checks each result field by field.
module hexagonal_bin_histogram_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOL = hbh_pkg::DEF_MAX_COLUMNS;
  localparam int NROW = hbh_pkg::DEF_MAX_ROWS;
  localparam int MAIN_CELLS = (NCOL + 1) * (NROW + 1);
  localparam int OFFS_CELLS = NCOL * NROW;
  localparam logic [23:0] COUNT_TOP = 24'hFFFFFF;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               lat;
    logic [7:0]         col;
    logic [6:0]         row;
  } hist_req_t;

  typedef struct packed {
    logic        binned;
    logic        lat;
    logic [7:0]  col;
    logic [6:0]  row;
    logic [23:0] cnt;
    logic        meets;
  } hist_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = hbh_pkg::MODE_BIN;
  logic signed [31:0] in_x_coord = '0;
  logic signed [31:0] in_y_coord = '0;
  logic in_lattice_select = hbh_pkg::LAT_MAIN;
  logic [7:0] in_column_select = '0;
  logic [6:0] in_row_select = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_binned, out_hit_lattice, out_meets_minimum;
  logic [7:0] out_hit_column;
  logic [6:0] out_hit_row;
  logic [23:0] out_cell_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hbh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hbh_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  hexagonal_bin_histogram DUT (.*);

  // Shadow copy of the configuration and of both count stores
  logic signed [31:0] org_x = '0, org_y = '0;
  logic [31:0] inv_x = hbh_pkg::RST_INV, inv_y = hbh_pkg::RST_INV;
  logic [7:0] grid_cols = hbh_pkg::RST_GRID_COLS;
  logic [6:0] grid_rows = hbh_pkg::RST_GRID_ROWS;
  logic [23:0] min_cnt = hbh_pkg::RST_MIN_COUNT;
  logic [23:0] main_cnt [MAIN_CELLS];
  logic [23:0] offs_cnt [OFFS_CELLS];

  hist_resp_t pending_results [$];
  bit failed = 1'b0;
  bit idle_on = 1'b1;
  int stall_cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic void queue_expected(hist_resp_t e);
    pending_results = {pending_results, e};
  endfunction

  function automatic int eff_cols();
    return (grid_cols < 1) ? 1 : (grid_cols > NCOL ? NCOL : int'(grid_cols));
  endfunction

  function automatic int eff_rows();
    return (grid_rows < 1) ? 1 : (grid_rows > NROW ? NROW : int'(grid_rows));
  endfunction

  // floor((coord - origin) * inverse pitch), Q.16
  function automatic longint scale_to_index(logic signed [31:0] c, logic signed [31:0] o,
                                            logic [31:0] inv);
    longint d;
    longint unsigned m, p;
    d = longint'(c) - longint'(o);
    m = (d < 0) ? longint'(-d) : d;
    p = m * {32'd0, inv};
    if (d >= 0) return longint'(p >> 16);
    return -longint'((p + 64'hFFFF) >> 16);
  endfunction

  function automatic longint round_half_away(longint s);
    if (s >= 0) return (s + 32768) >>> 16;
    return -((-s + 32768) >>> 16);
  endfunction

  function automatic hist_resp_t bin_or_read(hist_req_t rq);
    hist_resp_t r;
    longint s, t, ax, ay, bx, by, dax, day, dbx, dby, d1, d2;
    int k;
    r = '0;
    if (rq.mode == hbh_pkg::MODE_BIN) begin
      s = scale_to_index(rq.x, org_x, inv_x);
      t = scale_to_index(rq.y, org_y, inv_y);
      ax = round_half_away(s);
      ay = round_half_away(t);
      bx = s >>> 16;
      by = t >>> 16;
      dax = s - ax * 65536;
      day = t - ay * 65536;
      dbx = s - bx * 65536 - 32768;
      dby = t - by * 65536 - 32768;
      d1 = dax * dax + 3 * day * day;
      d2 = dbx * dbx + 3 * dby * dby;
      if (d1 < d2) begin
        r.lat = hbh_pkg::LAT_MAIN;
        if (ax >= 0 && ax <= eff_cols() && ay >= 0 && ay <= eff_rows()) begin
          k = int'(ax) * (NROW + 1) + int'(ay);
          if (main_cnt[k] != COUNT_TOP) main_cnt[k]++;
          r.binned = 1'b1;
          r.col = ax[7:0];
          r.row = ay[6:0];
        end
      end else begin
        r.lat = hbh_pkg::LAT_OFFS;
        if (bx >= 0 && bx < eff_cols() && by >= 0 && by < eff_rows()) begin
          k = int'(bx) * NROW + int'(by);
          if (offs_cnt[k] != COUNT_TOP) offs_cnt[k]++;
          r.binned = 1'b1;
          r.col = bx[7:0];
          r.row = by[6:0];
        end
      end
    end else begin
      if (rq.lat == hbh_pkg::LAT_MAIN) begin
        if (rq.col <= NCOL && rq.row <= NROW) begin
          k = int'(rq.col) * (NROW + 1) + int'(rq.row);
          r.cnt = main_cnt[k];
          main_cnt[k] = '0;
        end
      end else if (rq.col < NCOL && rq.row < NROW) begin
        k = int'(rq.col) * NROW + int'(rq.row);
        r.cnt = offs_cnt[k];
        offs_cnt[k] = '0;
      end
      r.meets = (r.cnt >= min_cnt);
    end
    return r;
  endfunction

  // Leaves in_valid high; the caller sends again or calls stop_input in the same step
  task automatic send_item(hist_req_t rq);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= rq.mode;
    in_x_coord <= rq.x;
    in_y_coord <= rq.y;
    in_lattice_select <= rq.lat;
    in_column_select <= rq.col;
    in_row_select <= rq.row;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    queue_expected(bin_or_read(rq));
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [hbh_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    drain_results();
    repeat (12) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      hbh_pkg::REG_X_ORIGIN:  org_x = value;
      hbh_pkg::REG_Y_ORIGIN:  org_y = value;
      hbh_pkg::REG_X_INV:     inv_x = value;
      hbh_pkg::REG_Y_INV:     inv_y = value;
      hbh_pkg::REG_GRID_COLS: grid_cols = value[7:0];
      hbh_pkg::REG_GRID_ROWS: grid_rows = value[6:0];
      hbh_pkg::REG_MIN_COUNT: min_cnt = value[23:0];
      default: ;
    endcase
  endtask

  function automatic hist_req_t point_at(logic signed [31:0] x, logic signed [31:0] y);
    hist_req_t rq;
    rq = '0;
    rq.mode = hbh_pkg::MODE_BIN;
    rq.x = x;
    rq.y = y;
    rq.lat = $urandom_range(0, 1);
    rq.col = $urandom_range(0, 128);
    rq.row = $urandom_range(0, 64);
    return rq;
  endfunction

  function automatic hist_req_t read_of(logic lat, int col, int row);
    hist_req_t rq;
    rq.mode = hbh_pkg::MODE_READ;
    rq.x = $urandom;
    rq.y = $urandom;
    rq.lat = lat;
    rq.col = col[7:0];
    rq.row = row[6:0];
    return rq;
  endfunction

  // Coordinate that lands mostly inside the grid, a cell's width of margin on each side
  function automatic logic signed [31:0] near_grid(logic signed [31:0] o, logic [31:0] inv,
                                                    int cells);
    longint span, d;
    if (inv < 32'h1000) return $urandom;
    span = (longint'(cells + 2) << 32) / longint'(inv);
    d = longint'($urandom) % span - span / (cells + 2);
    return 32'(longint'(o) + d);
  endfunction

  task automatic test_directed();
    idle_on = 1'b1;
    send_item(point_at(32'sh0000_0000, 32'sh0000_0000));
    send_item(point_at(32'sh0000_8000, 32'sh0000_8000));
    send_item(point_at(32'sh0000_4000, 32'sh0000_4000));
    send_item(point_at(32'sh0000_8000, 32'sh0000_0000));
    send_item(point_at(32'sh0000_0000, 32'sh0000_8000));
    send_item(point_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_item(point_at(32'sh8000_0000, 32'sh8000_0000));
    send_item(point_at(32'sh0064_0000, 32'sh0039_0000));
    send_item(point_at(32'sh0063_8000, 32'sh0038_8000));
    send_item(point_at(-32'sh0000_6666, -32'sh0000_6666));
    send_item(point_at(32'sh0064_8000, 32'sh0039_8000));
    send_item(point_at(32'sh0000_0000, 32'sh0000_0000));
    send_item(read_of(hbh_pkg::LAT_MAIN, 0, 0));
    send_item(read_of(hbh_pkg::LAT_MAIN, 0, 0));
    send_item(read_of(hbh_pkg::LAT_OFFS, 0, 0));
    send_item(read_of(hbh_pkg::LAT_MAIN, 100, 57));
    send_item(read_of(hbh_pkg::LAT_OFFS, 99, 56));
    send_item(read_of(hbh_pkg::LAT_MAIN, 128, 64));
    send_item(read_of(hbh_pkg::LAT_OFFS, 127, 63));
    send_item(read_of(hbh_pkg::LAT_OFFS, 128, 64));
    send_item(read_of(hbh_pkg::LAT_OFFS, 0, 64));
    send_item(read_of(hbh_pkg::LAT_MAIN, 1, 1));
    stop_input();
  endtask

  task automatic test_random_phases();
    hist_req_t rq;
    int r;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(hbh_pkg::REG_MIN_COUNT, 32'd0);
        end
        1: begin
          write_reg(hbh_pkg::REG_X_ORIGIN, 32'h8000_0000);
          write_reg(hbh_pkg::REG_Y_ORIGIN, 32'h7FFF_FFFF);
          write_reg(hbh_pkg::REG_X_INV, 32'h0000_1000);
          write_reg(hbh_pkg::REG_Y_INV, 32'h0000_1000);
          write_reg(hbh_pkg::REG_GRID_COLS, 32'd128);
          write_reg(hbh_pkg::REG_GRID_ROWS, 32'd64);
          write_reg(hbh_pkg::REG_MIN_COUNT, 32'd2);
        end
        2: begin
          write_reg(hbh_pkg::REG_X_ORIGIN, 32'hFFF0_0000);
          write_reg(hbh_pkg::REG_Y_ORIGIN, 32'h0010_0000);
          write_reg(hbh_pkg::REG_X_INV, 32'h0002_0000);
          write_reg(hbh_pkg::REG_Y_INV, 32'h0000_8000);
          write_reg(hbh_pkg::REG_GRID_COLS, 32'd1);
          write_reg(hbh_pkg::REG_GRID_ROWS, 32'd1);
          write_reg(hbh_pkg::REG_MIN_COUNT, 32'hFF_FFFF);
        end
        3: begin
          // Zero grid sizes clamp to one column and one row
          write_reg(hbh_pkg::REG_GRID_COLS, 32'd0);
          write_reg(hbh_pkg::REG_GRID_ROWS, 32'd0);
          write_reg(hbh_pkg::REG_X_INV, 32'hFFFF_FFFF);
          write_reg(hbh_pkg::REG_Y_INV, 32'd0);
          write_reg(hbh_pkg::REG_MIN_COUNT, 32'd1);
        end
        4: begin
          write_reg(hbh_pkg::REG_GRID_COLS, 32'd255);
          write_reg(hbh_pkg::REG_GRID_ROWS, 32'd127);
          write_reg(hbh_pkg::REG_X_INV, 32'h0001_0000);
          write_reg(hbh_pkg::REG_Y_INV, 32'h0001_8000);
          write_reg(hbh_pkg::REG_X_ORIGIN, 32'd0);
          write_reg(hbh_pkg::REG_Y_ORIGIN, 32'd0);
        end
        default: begin
          write_reg(hbh_pkg::REG_X_ORIGIN, $urandom);
          write_reg(hbh_pkg::REG_Y_ORIGIN, $urandom);
          write_reg(hbh_pkg::REG_X_INV, $urandom_range(32'h4000, 32'h40000));
          write_reg(hbh_pkg::REG_Y_INV, $urandom_range(32'h4000, 32'h40000));
          write_reg(hbh_pkg::REG_GRID_COLS, $urandom_range(1, 128));
          write_reg(hbh_pkg::REG_GRID_ROWS, $urandom_range(1, 64));
          write_reg(hbh_pkg::REG_MIN_COUNT, $urandom_range(0, 4));
        end
      endcase
      for (int n = 0; n < 210; n++) begin
        if (n % 70 == 0) idle_on = $urandom_range(0, 2) != 0;
        r = $urandom_range(0, 99);
        if (r < 65) begin
          rq = point_at(near_grid(org_x, inv_x, eff_cols()),
                        near_grid(org_y, inv_y, eff_rows()));
        end else if (r < 75) begin
          rq = point_at($urandom, $urandom);
        end else if (r < 90) begin
          rq = read_of($urandom_range(0, 1), $urandom_range(0, eff_cols()),
                       $urandom_range(0, eff_rows()));
        end else begin
          rq = read_of($urandom_range(0, 1), $urandom_range(0, 128), $urandom_range(0, 64));
        end
        send_item(rq);
      end
      stop_input();
    end
  endtask

  // Sender holds off until the block has returned every result, then resumes
  task automatic test_hold_off();
    idle_on = 1'b0;
    for (int n = 0; n < 20; n++) begin
      send_item(point_at(near_grid(org_x, inv_x, eff_cols()),
                         near_grid(org_y, inv_y, eff_rows())));
      if (n == 9) begin
        stop_input();
        drain_results();
      end
    end
    stop_input();
  endtask

  // Result side: random stall before each transfer while idle_on is set
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      gap = idle_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    hist_resp_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        failed = 1'b1;
      end else begin
        e = pending_results.pop_front();
        if (out_binned !== e.binned) begin
          $error("binned: expected %0d, got %0d", e.binned, out_binned);
          failed = 1'b1;
        end
        if (out_hit_lattice !== e.lat) begin
          $error("hit_lattice: expected %0d, got %0d", e.lat, out_hit_lattice);
          failed = 1'b1;
        end
        if (out_hit_column !== e.col) begin
          $error("hit_column: expected %0d, got %0d", e.col, out_hit_column);
          failed = 1'b1;
        end
        if (out_hit_row !== e.row) begin
          $error("hit_row: expected %0d, got %0d", e.row, out_hit_row);
          failed = 1'b1;
        end
        if (out_cell_count !== e.cnt) begin
          $error("cell_count: expected %0d, got %0d", e.cnt, out_cell_count);
          failed = 1'b1;
        end
        if (out_meets_minimum !== e.meets) begin
          $error("meets_minimum: expected %0d, got %0d", e.meets, out_meets_minimum);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: cycles without any transfer; covers the clearing pass after reset
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("hexagonal_bin_histogram_test NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (main_cnt[i]) main_cnt[i] = '0;
    foreach (offs_cnt[i]) offs_cnt[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_hold_off();
    drain_results();
    repeat (30) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("hexagonal_bin_histogram_test OK");
    end else begin
      $display("hexagonal_bin_histogram_test NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
sv/hbh_pkg.sv
sv/hbh_count_mem.sv
sv/hexagonal_bin_histogram.sv
sv/hbh_checker.sv
test/hexagonal_bin_histogram_test.sv
